[src/punch_session_table_core_macros.svh]
// Assertion macros for the session table core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PUNCH_SESSION_TABLE_CORE_MACROS_SVH
`define PUNCH_SESSION_TABLE_CORE_MACROS_SVH

// Check under reset qualification.
`define PST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that also holds while reset is applied.
`define PST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/pst_pkg.sv]
// Package for the session table core: record type, codes and the tick update.
// No dependencies.
`timescale 1ns / 1ps
package pst_pkg;

  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_RELAY = 3'd1;
  localparam logic [2:0] REQ_FWD   = 3'd2;
  localparam logic [2:0] REQ_ACK   = 3'd3;
  localparam logic [2:0] REQ_QUERY = 3'd4;
  localparam logic [2:0] REQ_TICK  = 3'd5;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_REQ     = 3'd1;
  localparam logic [2:0] PH_FWD     = 3'd2;
  localparam logic [2:0] PH_CONN    = 3'd3;
  localparam logic [2:0] PH_TIMEOUT = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  localparam logic [30:0] TIMEOUT_RST = 31'd8000;
  localparam logic [30:0] RETRY_RST   = 31'd1000;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [2:0]  phase;
    logic [31:0] start;
    logic [31:0] send;
    logic [15:0] retries;
  } rec_t;

  typedef struct packed {
    logic evict;
    rec_t rec;
  } tick_t;

  // Age one valid record: evict settled ones, time out or count a retry.
  function automatic tick_t tick_update(rec_t r, logic [31:0] now,
                                        logic [30:0] tmo, logic [30:0] rty);
    tick_t       t;
    logic [31:0] age;
    logic [31:0] since;
    t       = '0;
    t.rec   = r;
    age     = now - r.start;
    since   = now - r.send;
    if (r.phase == PH_CONN || r.phase == PH_TIMEOUT) begin
      t.evict = ({1'b0, age} > {1'b0, tmo, 1'b0});
    end else if (age > {1'b0, tmo}) begin
      t.rec.phase = PH_TIMEOUT;
    end else if (since > {1'b0, rty}) begin
      t.rec.send = now;
      if (r.retries != 16'hFFFF) begin
        t.rec.retries = r.retries + 16'd1;
      end
    end
    return t;
  endfunction

endpackage

[src/pst_mem.sv]
// Record memory: one write port, one registered read port.
// Depends on pst_pkg for the record type.
`timescale 1ns / 1ps
module pst_mem #(
  parameter int Depth = 32,
  parameter int Aw    = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [Aw-1:0]     waddr_i,
  input  pst_pkg::rec_t     wdata_i,
  input  logic [Aw-1:0]     raddr_i,
  output pst_pkg::rec_t     rdata_o
);

  pst_pkg::rec_t mem [Depth];
  pst_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/punch_session_table_core.sv]
// Session table core: each request is served by one pass over the record memory,
// one entry read per cycle.
// One request in flight.
// The next request is taken while a result waits in the output register.
// Reset clears valid bits and fill count and sets the id counter to one at once; no clearing pass.
`timescale 1ns / 1ps
`include "punch_session_table_core_macros.svh"
module punch_session_table_core #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] session_id_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] new_session_id_o,
  output logic [2:0]  session_state_o,
  output logic [15:0] retry_count_o
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_N = CW'(TABLE_ENTRIES);

  // Control state
  pst_pkg::state_e      state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;       // next entry to read
  logic                 dv_q, dv_d;         // read data valid this cycle
  logic [IW-1:0]        didx_q, didx_d;     // entry of the read data
  logic                 hit_q, hit_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]        used_q, used_d;
  logic [31:0]          next_key_q, next_key_d;
  logic [30:0]          tmo_q, rty_q;
  logic                 out_valid_q, out_valid_d;

  // Payload
  logic [2:0]           type_q, type_d;
  logic [31:0]          sid_q, sid_d;
  logic [31:0]          now_q, now_d;
  logic [IW-1:0]        hit_idx_q, hit_idx_d;
  pst_pkg::rec_t        hit_rec_q, hit_rec_d;
  logic [1:0]           status_q, status_d;
  logic [31:0]          newid_q, newid_d;
  logic [2:0]           phase_q, phase_d;
  logic [15:0]          retries_q, retries_d;

  // Memory port
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  pst_pkg::rec_t        mem_wdata;
  pst_pkg::rec_t        mem_rdata;

  pst_pkg::tick_t       upd;
  logic [IW-1:0]        free_idx;
  logic [31:0]          tgt_key;
  logic [31:0]          key_inc;
  pst_pkg::rec_t        fill_rec;

  pst_mem #(.Depth(TABLE_ENTRIES), .Aw(IW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Lowest free slot; only used when the table is not full.
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end

  // Start looks up the id it would hand out; all others look up the request id.
  assign tgt_key = (type_q == pst_pkg::REQ_START) ? next_key_q : sid_q;
  assign key_inc = next_key_q + 32'd1;
  assign upd     = pst_pkg::tick_update(mem_rdata, now_q, tmo_q, rty_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dv_d        = 1'b0;
    didx_d      = cnt_q[IW-1:0];
    hit_d       = hit_q;
    valid_d     = valid_q;
    used_d      = used_q;
    next_key_d  = next_key_q;
    type_d      = type_q;
    sid_d       = sid_q;
    now_d       = now_q;
    hit_idx_d   = hit_idx_q;
    hit_rec_d   = hit_rec_q;
    status_d    = status_q;
    newid_d     = newid_q;
    phase_d     = phase_q;
    retries_d   = retries_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = didx_q;
    mem_wdata   = upd.rec;
    fill_rec    = '0;

    unique case (state_q)
      pst_pkg::S_IDLE: begin
        // Take the request and start a pass at entry zero.
        if (in_valid_i) begin
          type_d  = req_type_i;
          sid_d   = session_id_i;
          now_d   = now_ms_i;
          cnt_d   = '0;
          hit_d   = 1'b0;
          state_d = pst_pkg::S_SCAN;
        end
      end

      pst_pkg::S_SCAN: begin
        // Issue one read per cycle until every entry has been requested.
        if (cnt_q != CNT_N) begin
          cnt_d = cnt_q + CW'(1);
          dv_d  = 1'b1;
        end
        // Examine the entry whose data just came back.
        if (dv_q && valid_q[didx_q]) begin
          if (type_q == pst_pkg::REQ_TICK) begin
            if (upd.evict) begin
              valid_d[didx_q] = 1'b0;
              used_d          = used_q - CW'(1);
            end else begin
              mem_we = 1'b1;
            end
          end else if (!hit_q && mem_rdata.key == tgt_key) begin
            hit_d     = 1'b1;
            hit_idx_d = didx_q;
            hit_rec_d = mem_rdata;
          end
        end
        if (cnt_q == CNT_N && !dv_q) begin
          state_d = pst_pkg::S_FIN;
        end
      end

      pst_pkg::S_FIN: begin
        // Wait for the output register, then commit and report.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = pst_pkg::ST_DONE;
          newid_d     = '0;
          phase_d     = pst_pkg::PH_IDLE;
          retries_d   = '0;
          state_d     = pst_pkg::S_IDLE;
          fill_rec.key   = tgt_key;
          fill_rec.start = now_q;
          fill_rec.send  = now_q;
          case (type_q)
            pst_pkg::REQ_START: begin
              if (used_q == CNT_N) begin
                status_d = pst_pkg::ST_FULL;
              end else begin
                // Overwrite a record with the same id in place.
                fill_rec.phase = pst_pkg::PH_REQ;
                mem_we    = 1'b1;
                mem_waddr = hit_q ? hit_idx_q : free_idx;
                mem_wdata = fill_rec;
                valid_d[mem_waddr] = 1'b1;
                if (!hit_q) used_d = used_q + CW'(1);
                next_key_d = (key_inc == 32'd0) ? 32'd1 : key_inc;
                newid_d    = next_key_q;
                phase_d    = pst_pkg::PH_REQ;
              end
            end
            pst_pkg::REQ_RELAY, pst_pkg::REQ_FWD: begin
              if (hit_q) begin
                phase_d   = hit_rec_q.phase;
                retries_d = hit_rec_q.retries;
              end else if (used_q != CNT_N) begin
                fill_rec.phase = (type_q == pst_pkg::REQ_RELAY) ?
                                 pst_pkg::PH_FWD : pst_pkg::PH_REQ;
                mem_we    = 1'b1;
                mem_waddr = free_idx;
                mem_wdata = fill_rec;
                valid_d[free_idx] = 1'b1;
                used_d    = used_q + CW'(1);
                phase_d   = fill_rec.phase;
              end else begin
                status_d = pst_pkg::ST_FULL;
              end
            end
            pst_pkg::REQ_ACK, pst_pkg::REQ_QUERY: begin
              if (!hit_q) begin
                status_d = pst_pkg::ST_NOTFOUND;
              end else begin
                retries_d = hit_rec_q.retries;
                phase_d   = hit_rec_q.phase;
                if (type_q == pst_pkg::REQ_ACK) begin
                  mem_we          = 1'b1;
                  mem_waddr       = hit_idx_q;
                  mem_wdata       = hit_rec_q;
                  mem_wdata.phase = pst_pkg::PH_CONN;
                  phase_d         = pst_pkg::PH_CONN;
                end
              end
            end
            default: begin
              // Tick and unknown codes report all zero.
            end
          endcase
        end
      end

      default: state_d = pst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pst_pkg::S_IDLE;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      didx_q      <= '0;
      hit_q       <= 1'b0;
      valid_q     <= '0;
      used_q      <= '0;
      next_key_q  <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      didx_q      <= didx_d;
      hit_q       <= hit_d;
      valid_q     <= valid_d;
      used_q      <= used_d;
      next_key_q  <= next_key_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= pst_pkg::TIMEOUT_RST;
      rty_q <= pst_pkg::RETRY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pst_pkg::CFG_TIMEOUT: tmo_q <= cfg_data_i;
        pst_pkg::CFG_RETRY:   rty_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    sid_q     <= sid_d;
    now_q     <= now_d;
    hit_idx_q <= hit_idx_d;
    hit_rec_q <= hit_rec_d;
    status_q  <= status_d;
    newid_q   <= newid_d;
    phase_q   <= phase_d;
    retries_q <= retries_d;
  end

  assign in_ready_o       = (state_q == pst_pkg::S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign new_session_id_o = newid_q;
  assign session_state_o  = phase_q;
  assign retry_count_o    = retries_q;

  `PST_ASSERT(a_used_bound, used_q <= CNT_N, "fill count above table size")
  `PST_ASSERT(a_used_match, int'(used_q) == $countones(valid_q), "fill count off valid bits")
  `PST_ASSERT(a_key_nonzero, next_key_q != 32'd0, "id counter reached zero")
  `PST_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> used_q == '0 || rst_ni, "table not empty in reset")

endmodule

[dv/tb_punch_session_table_core.sv]
// Testbench for punch_session_table_core: random and directed session requests
// checked against a behavioral predictor. Depends on pst_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_punch_session_table_core;

  localparam int ENTRIES  = 32;
  localparam int WDOG_MAX = 3000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] sid;
    logic [31:0] now;
  } session_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_id;
    logic [2:0]  state;
    logic [15:0] retries;
  } session_rsp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [30:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  req_type_i;
  logic [31:0] session_id_i;
  logic [31:0] now_ms_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] new_session_id_o;
  logic [2:0]  session_state_o;
  logic [15:0] retry_count_o;

  punch_session_table_core #(.TABLE_ENTRIES(ENTRIES)) i_dut (.*);

  // Shadow copy of the session table, updated on every accepted request.
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_key   [ENTRIES];
  logic [2:0]  tbl_phase [ENTRIES];
  logic [31:0] tbl_start [ENTRIES];
  logic [31:0] tbl_send  [ENTRIES];
  logic [15:0] tbl_retry [ENTRIES];
  logic [31:0] key_ctr;
  logic [30:0] timeout_ms;
  logic [30:0] retry_ms;

  session_req_t pending_reqs[$];
  session_rsp_t expected_rsps[$];
  int           errors;
  int           quiet_cycles;
  bit           no_gaps;
  int           starts_sent;
  logic [31:0]  gen_now;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int lookup_key(logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < ENTRIES; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  function automatic void open_record(int i, logic [31:0] k, logic [2:0] ph, logic [31:0] t);
    tbl_valid[i] = 1'b1;
    tbl_key[i]   = k;
    tbl_phase[i] = ph;
    tbl_start[i] = t;
    tbl_send[i]  = t;
    tbl_retry[i] = '0;
  endfunction

  // Apply one request to the shadow table and return the response it must produce.
  function automatic session_rsp_t apply_session_req(session_req_t r);
    session_rsp_t rsp;
    int           slot;
    int           used;
    logic [31:0]  k;
    logic [31:0]  age;
    logic [31:0]  since;
    rsp  = '0;
    slot = -1;
    case (r.kind)
      pst_pkg::REQ_START: begin
        used = 0;
        for (int i = 0; i < ENTRIES; i++) used += tbl_valid[i];
        if (used >= ENTRIES) begin
          rsp.status = pst_pkg::ST_FULL;
        end else begin
          k       = key_ctr;
          key_ctr = key_ctr + 32'd1;
          if (key_ctr == 32'd0) key_ctr = 32'd1;
          slot = lookup_key(k);
          if (slot < 0) slot = lowest_free();
          open_record(slot, k, pst_pkg::PH_REQ, r.now);
          rsp.new_id = k;
        end
      end
      pst_pkg::REQ_RELAY, pst_pkg::REQ_FWD: begin
        slot = lookup_key(r.sid);
        if (slot < 0) begin
          slot = lowest_free();
          if (slot >= 0)
            open_record(slot, r.sid, (r.kind == pst_pkg::REQ_RELAY) ?
                        pst_pkg::PH_FWD : pst_pkg::PH_REQ, r.now);
          else rsp.status = pst_pkg::ST_FULL;
        end
      end
      pst_pkg::REQ_ACK, pst_pkg::REQ_QUERY: begin
        slot = lookup_key(r.sid);
        if (slot < 0) rsp.status = pst_pkg::ST_NOTFOUND;
        else if (r.kind == pst_pkg::REQ_ACK) tbl_phase[slot] = pst_pkg::PH_CONN;
      end
      pst_pkg::REQ_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            age   = r.now - tbl_start[i];
            since = r.now - tbl_send[i];
            if (tbl_phase[i] == pst_pkg::PH_CONN || tbl_phase[i] == pst_pkg::PH_TIMEOUT) begin
              if ({1'b0, age} > ({2'b00, timeout_ms} << 1)) tbl_valid[i] = 1'b0;
            end else if (age > {1'b0, timeout_ms}) begin
              tbl_phase[i] = pst_pkg::PH_TIMEOUT;
            end else if (since > {1'b0, retry_ms}) begin
              tbl_send[i] = r.now;
              if (tbl_retry[i] != 16'hFFFF) tbl_retry[i] = tbl_retry[i] + 16'd1;
            end
          end
        end
      end
      default: ;
    endcase
    if (slot >= 0) begin
      rsp.state   = tbl_phase[slot];
      rsp.retries = tbl_retry[slot];
    end
    return rsp;
  endfunction

  // Driver: advance to the next request once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    session_req_t nxt;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= '0;
      session_id_i <= '0;
      now_ms_i     <= '0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_rsps.push_back(apply_session_req({req_type_i, session_id_i, now_ms_i}));
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() > 0 && (no_gaps || $urandom_range(99) >= 17)) begin
          nxt = pending_reqs.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= nxt.kind;
          session_id_i <= nxt.sid;
          now_ms_i     <= nxt.now;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response against the oldest expectation, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    session_rsp_t exp_rsp;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_ready_i <= no_gaps || ($urandom_range(99) >= 17);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, got %h", $time,
                   {status_o, new_session_id_o, session_state_o, retry_count_o});
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (status_o !== exp_rsp.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_rsp.status, status_o);
            errors++;
          end
          if (new_session_id_o !== exp_rsp.new_id) begin
            $display("%0t: new id expected %h got %h", $time, exp_rsp.new_id,
                     new_session_id_o);
            errors++;
          end
          if (session_state_o !== exp_rsp.state) begin
            $display("%0t: state expected %0d got %0d", $time, exp_rsp.state,
                     session_state_o);
            errors++;
          end
          if (retry_count_o !== exp_rsp.retries) begin
            $display("%0t: retries expected %0d got %0d", $time, exp_rsp.retries,
                     retry_count_o);
            errors++;
          end
        end
      end
    end
  end

  // Hang detector: nothing moving for too long ends the run.
  always @(posedge clk_i) begin
    if (quiet_cycles >= WDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_req(logic [2:0] kind, logic [31:0] sid, logic [31:0] t);
    pending_reqs.push_back('{kind: kind, sid: sid, now: t});
    if (kind == pst_pkg::REQ_START) starts_sent++;
  endtask

  // Hold until every response is back, then let the core settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pst_pkg::CFG_TIMEOUT) timeout_ms = val;
    else retry_ms = val;
  endtask

  // Random session traffic; keys mostly hit ids already in play.
  task automatic random_traffic(int n, int max_step);
    int          pick;
    logic [31:0] sid;
    logic [2:0]  kind;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 75) sid = $urandom_range(0, starts_sent + 40);
      else sid = $urandom;
      if (pick < 3) gen_now = $urandom;
      else gen_now = gen_now + $urandom_range(0, max_step);
      pick = $urandom_range(99);
      if      (pick < 15) kind = pst_pkg::REQ_START;
      else if (pick < 33) kind = pst_pkg::REQ_RELAY;
      else if (pick < 48) kind = pst_pkg::REQ_FWD;
      else if (pick < 63) kind = pst_pkg::REQ_ACK;
      else if (pick < 78) kind = pst_pkg::REQ_QUERY;
      else if (pick < 96) kind = pst_pkg::REQ_TICK;
      else kind = 3'($urandom_range(6, 7));
      push_req(kind, sid, gen_now);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = 1'b0;
    cfg_data_i  = '0;
    errors      = 0;
    no_gaps     = 1'b0;
    starts_sent = 0;
    gen_now     = 32'd0;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    key_ctr    = 32'd1;
    timeout_ms = pst_pkg::TIMEOUT_RST;
    retry_ms   = pst_pkg::RETRY_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: each request kind, unknown ids, odd codes and wrapping time.
    push_req(pst_pkg::REQ_START, 32'hFFFF_FFFF, 32'd0);
    push_req(pst_pkg::REQ_RELAY, 32'd0, 32'd10);
    push_req(pst_pkg::REQ_FWD, 32'hFFFF_FFFF, 32'd20);
    push_req(pst_pkg::REQ_RELAY, 32'hFFFF_FFFF, 32'd30);
    push_req(pst_pkg::REQ_FWD, 32'd1, 32'd40);
    push_req(pst_pkg::REQ_ACK, 32'h1234_5678, 32'd50);
    push_req(pst_pkg::REQ_QUERY, 32'h8765_4321, 32'd60);
    push_req(pst_pkg::REQ_ACK, 32'd0, 32'd70);
    push_req(pst_pkg::REQ_QUERY, 32'd0, 32'd80);
    push_req(pst_pkg::REQ_TICK, 32'd0, 32'd1500);
    push_req(pst_pkg::REQ_QUERY, 32'd1, 32'd1600);
    push_req(pst_pkg::REQ_TICK, 32'd0, 32'd9000);
    push_req(pst_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'd9001);
    push_req(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(3'd7, 32'hAAAA_5555, 32'h5555_AAAA);
    push_req(pst_pkg::REQ_TICK, 32'd0, 32'd17000);
    push_req(pst_pkg::REQ_TICK, 32'd0, 32'hFFFF_FFFF);
    push_req(pst_pkg::REQ_START, 32'd0, 32'hFFFF_FFF0);
    push_req(pst_pkg::REQ_TICK, 32'd0, 32'd100);
    push_req(pst_pkg::REQ_QUERY, 32'd2, 32'd200);
    drain();

    // Default registers, gapless stretch.
    no_gaps = 1'b1;
    random_traffic(70, 600);
    drain();
    no_gaps = 1'b0;

    // Longest lifetime: fill the table past capacity, then start and forward while full.
    write_reg(pst_pkg::CFG_TIMEOUT, 31'h7FFF_FFFF);
    write_reg(pst_pkg::CFG_RETRY, 31'h7FFF_FFFF);
    for (int i = 0; i < 36; i++) push_req(pst_pkg::REQ_RELAY, $urandom, gen_now + i);
    push_req(pst_pkg::REQ_START, 32'd0, gen_now);
    push_req(pst_pkg::REQ_FWD, $urandom, gen_now);
    random_traffic(50, 100000);
    drain();

    // Shortest intervals: nearly every tick ages records.
    write_reg(pst_pkg::CFG_TIMEOUT, 31'd1);
    write_reg(pst_pkg::CFG_RETRY, 31'd1);
    random_traffic(80, 3);
    drain();

    // Zero registers, then times near the wrap point.
    write_reg(pst_pkg::CFG_TIMEOUT, 31'd0);
    write_reg(pst_pkg::CFG_RETRY, 31'd0);
    gen_now = 32'hFFFF_FF00;
    random_traffic(60, 4);
    drain();

    // Mid-range settings with retries well inside the lifetime.
    write_reg(pst_pkg::CFG_TIMEOUT, 31'd5000);
    write_reg(pst_pkg::CFG_RETRY, 31'd100);
    random_traffic(90, 300);
    drain();

    write_reg(pst_pkg::CFG_TIMEOUT, 31'($urandom));
    write_reg(pst_pkg::CFG_RETRY, 31'($urandom_range(1, 5000)));
    random_traffic(70, 20000);
    drain();

    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
